// ----- sv/sbma_pkg.sv -----
package sbma_pkg;

	localparam int unsigned MEM_BYTES_DEF = 65536;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned LANES = DATA_W / 8;
	localparam int unsigned ROW_W = 2 * DATA_W;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [LANES-1:0] lane_mask_t;

	function automatic lane_mask_t size_mask(input logic [1:0] size);
		lane_mask_t m;
		int unsigned cnt;
		cnt = 1 << size;
		for (int unsigned j = 0; j < LANES; j++) begin
			m[j] = (j < cnt);
		end
		return m;
	endfunction

	function automatic word_t keep_bytes(input word_t w, input logic [1:0] size);
		word_t r;
		lane_mask_t m;
		m = size_mask(size);
		for (int unsigned j = 0; j < LANES; j++) begin
			r[8*j +: 8] = m[j] ? w[8*j +: 8] : 8'h00;
		end
		return r;
	endfunction

	function automatic word_t swap_bytes(input word_t w, input logic [1:0] size);
		word_t r;
		int unsigned cnt;
		cnt = 1 << size;
		r = '0;
		for (int unsigned j = 0; j < LANES; j++) begin
			if (j < cnt) begin
				r[8*j +: 8] = w[8*(cnt-1-j) +: 8];
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/sbma_bank.sv -----
module sbma_bank #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW = 12
) (
	input  logic                        clk,
	input  logic [sbma_pkg::LANES-1:0]  wbe,
	input  logic [AW-1:0]               waddr,
	input  sbma_pkg::word_t             wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output sbma_pkg::word_t             rdata
);

	sbma_pkg::word_t mem [DEPTH];
	sbma_pkg::word_t rdata_q;

	always_ff @(posedge clk) begin
		for (int unsigned b = 0; b < sbma_pkg::LANES; b++) begin
			if (wbe[b]) begin
				mem[waddr][8*b +: 8] <= wdata[8*b +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/sized_byte_memory_access.sv -----
// Byte-addressed memory of MEM_BYTES bytes with read and write accesses of 1, 2, 4 or 8
// bytes at any byte address. Storage is two banks of 8-byte rows (even and odd rows), so an
// unaligned access touches at most one row in each bank. An access whose last byte lies at
// or beyond MEM_BYTES is refused: memory is untouched, read data is zero and range_error is
// set. Byte order comes from cfg_wdata (1 little endian, the reset value; 0 big endian).
// After reset the banks are zeroed one row per cycle, ceil(MEM_BYTES/16) rows each (4096 at
// the default size), with s_tready low. After that the block takes one transfer per cycle
// while the output is taken; the banks are read at the accepting edge into the read stage,
// and the output register loads from that stage once the output is free.
module sized_byte_memory_access #(
	parameter int unsigned MEM_BYTES = sbma_pkg::MEM_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic          cfg_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [103:0]  s_tdata,  // access_size[1:0], byte_address[33:2], write_value[97:34]
	input  logic          s_tuser,  // opcode
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [63:0]   m_tdata,  // read_value
	output logic          m_tuser   // range_error
);

	localparam int unsigned BANK_ROWS = (MEM_BYTES + 15) / 16;
	localparam int unsigned BANK_AW = $clog2(BANK_ROWS);

	logic                       le_q;
	logic [BANK_AW-1:0]         clr_cnt_q;
	logic                       clr_done_q;

	logic [1:0]                 in_size;
	logic [31:0]                in_addr;
	sbma_pkg::word_t            in_wval;
	logic                       acc;
	logic [32:0]                last_byte;
	logic                       in_err;
	logic                       do_wr;
	logic                       do_rd;
	logic [2:0]                 in_off;
	logic                       in_odd;
	logic [BANK_AW-1:0]         row_half;
	logic [BANK_AW-1:0]         row_half_inc;
	sbma_pkg::word_t            wstream;
	logic [sbma_pkg::ROW_W-1:0] wwin;
	logic [2*sbma_pkg::LANES-1:0] wbe16;

	logic [sbma_pkg::LANES-1:0] b0_wbe;
	logic [sbma_pkg::LANES-1:0] b1_wbe;
	logic [BANK_AW-1:0]         b0_addr;
	logic [BANK_AW-1:0]         b1_addr;
	sbma_pkg::word_t            b0_wdata;
	sbma_pkg::word_t            b1_wdata;
	sbma_pkg::word_t            b0_rdata;
	sbma_pkg::word_t            b1_rdata;

	logic                       vld_s1;
	logic                       rd_s1;
	logic                       err_s1;
	logic [2:0]                 off_s1;
	logic [1:0]                 size_s1;
	logic                       odd_s1;
	logic                       le_s1;

	logic [sbma_pkg::ROW_W-1:0] rwin;
	logic [sbma_pkg::ROW_W-1:0] rshift;
	sbma_pkg::word_t            rstream;
	sbma_pkg::word_t            rval;

	logic                       out_vld_q;
	sbma_pkg::word_t            out_val_q;
	logic                       out_err_q;
	logic                       out_free;

	assign in_size = s_tdata[1:0];
	assign in_addr = s_tdata[33:2];
	assign in_wval = s_tdata[97:34];

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = clr_done_q && (!vld_s1 || out_free);
	assign acc = s_tvalid && s_tready;

	assign last_byte = {1'b0, in_addr} + (33'd1 << in_size) - 33'd1;
	assign in_err = (last_byte >= 33'(MEM_BYTES));
	assign do_wr = acc && (s_tuser == sbma_pkg::OP_WRITE) && !in_err;
	assign do_rd = acc && (s_tuser == sbma_pkg::OP_READ) && !in_err;

	assign in_off = in_addr[2:0];
	assign in_odd = in_addr[3];
	assign row_half = in_addr[4 +: BANK_AW];
	assign row_half_inc = row_half + BANK_AW'(1);

	always_comb begin
		wstream = le_q ? sbma_pkg::keep_bytes(in_wval, in_size)
			: sbma_pkg::swap_bytes(in_wval, in_size);
		wwin = {{sbma_pkg::DATA_W{1'b0}}, wstream} << {in_off, 3'b000};
		wbe16 = {{sbma_pkg::LANES{1'b0}}, sbma_pkg::size_mask(in_size)} << in_off;
	end

	always_comb begin
		b0_addr = in_odd ? row_half_inc : row_half;
		b1_addr = row_half;
		b0_wdata = in_odd ? wwin[sbma_pkg::ROW_W-1:sbma_pkg::DATA_W]
			: wwin[sbma_pkg::DATA_W-1:0];
		b1_wdata = in_odd ? wwin[sbma_pkg::DATA_W-1:0]
			: wwin[sbma_pkg::ROW_W-1:sbma_pkg::DATA_W];
		b0_wbe = '0;
		b1_wbe = '0;
		if (!clr_done_q) begin
			b0_addr = clr_cnt_q;
			b1_addr = clr_cnt_q;
			b0_wdata = '0;
			b1_wdata = '0;
			b0_wbe = '1;
			b1_wbe = '1;
		end else if (do_wr) begin
			b0_wbe = in_odd ? wbe16[2*sbma_pkg::LANES-1:sbma_pkg::LANES]
				: wbe16[sbma_pkg::LANES-1:0];
			b1_wbe = in_odd ? wbe16[sbma_pkg::LANES-1:0]
				: wbe16[2*sbma_pkg::LANES-1:sbma_pkg::LANES];
		end
	end

	sbma_bank #(
		.DEPTH(BANK_ROWS),
		.AW   (BANK_AW)
	) u_bank_even (
		.clk  (clk),
		.wbe  (b0_wbe),
		.waddr(b0_addr),
		.wdata(b0_wdata),
		.re   (do_rd),
		.raddr(b0_addr),
		.rdata(b0_rdata)
	);

	sbma_bank #(
		.DEPTH(BANK_ROWS),
		.AW   (BANK_AW)
	) u_bank_odd (
		.clk  (clk),
		.wbe  (b1_wbe),
		.waddr(b1_addr),
		.wdata(b1_wdata),
		.re   (do_rd),
		.raddr(b1_addr),
		.rdata(b1_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q <= 1'b1;
		end else if (cfg_wen) begin
			le_q <= cfg_wdata;
		end
	end

	// zero both banks after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			if (clr_cnt_q == BANK_AW'(BANK_ROWS - 1)) begin
				clr_done_q <= 1'b1;
			end else begin
				clr_cnt_q <= clr_cnt_q + BANK_AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= (s_tuser == sbma_pkg::OP_READ);
			err_s1 <= in_err;
			off_s1 <= in_off;
			size_s1 <= in_size;
			odd_s1 <= in_odd;
			le_s1 <= le_q;
		end
	end

	always_comb begin
		rwin = odd_s1 ? {b0_rdata, b1_rdata} : {b1_rdata, b0_rdata};
		rshift = rwin >> {off_s1, 3'b000};
		rstream = sbma_pkg::keep_bytes(rshift[sbma_pkg::DATA_W-1:0], size_s1);
		rval = '0;
		if (rd_s1 && !err_s1) begin
			rval = le_s1 ? rstream : sbma_pkg::swap_bytes(rstream, size_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s1) begin
			out_val_q <= rval;
			out_err_q <= err_s1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_val_q;
	assign m_tuser = out_err_q;

	a_no_accept_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> clr_done_q)
		else $error("transfer accepted while banks are being cleared");

	a_refused_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("refused access returned nonzero data");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && out_vld_q && !m_tready) |=> (vld_s1 && $stable(b0_rdata)
			&& $stable(b1_rdata)))
		else $error("read stage lost its data under backpressure");

	a_no_bank_write_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(clr_done_q && acc && in_err) |-> (b0_wbe == '0 && b1_wbe == '0))
		else $error("refused access wrote memory");

endmodule

// ----- tb/sv/sized_byte_memory_access_test.sv -----
module sized_byte_memory_access_test;

	localparam int unsigned IMAGE_BYTES = sbma_pkg::MEM_BYTES_DEF;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASE_ITEMS = 617;

	localparam logic [1:0] SZ_BYTE  = 2'd0;
	localparam logic [1:0] SZ_HALF  = 2'd1;
	localparam logic [1:0] SZ_WORD  = 2'd2;
	localparam logic [1:0] SZ_DWORD = 2'd3;

	localparam logic LE_ORDER = 1'b1;
	localparam logic BE_ORDER = 1'b0;

	typedef struct packed {
		sbma_pkg::word_t read_value;
		logic            range_error;
	} mem_result_t;

	typedef struct {
		sbma_pkg::op_t   op;
		logic [1:0]      size;
		logic [31:0]     addr;
		sbma_pkg::word_t wval;
		bit              typed;
		mem_result_t     want;
	} access_row_t;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          cfg_wen = 1'b0;
	logic          cfg_wdata = 1'b1;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [103:0]  s_tdata = '0;  // access_size[1:0], byte_address[33:2], write_value[97:34]
	logic          s_tuser = 1'b0;  // opcode
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [63:0]   m_tdata;  // read_value
	logic          m_tuser;  // range_error

	logic [7:0]    mem_image [0:IMAGE_BYTES-1];
	logic          byte_order_le;
	mem_result_t   expected_results [$];
	access_row_t   directed_rows [24];

	int unsigned   src_idle_pct = 0;
	int unsigned   rcv_idle_pct = 0;
	int unsigned   mismatch_count = 0;
	int unsigned   stall_cycles = 0;
	int unsigned   read_count = 0;
	int unsigned   write_count = 0;
	int unsigned   refused_count = 0;

	sized_byte_memory_access #(
		.MEM_BYTES(IMAGE_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic mem_result_t predict_access(input sbma_pkg::op_t op,
			input logic [1:0] size, input logic [31:0] addr, input sbma_pkg::word_t wval);
		mem_result_t r;
		int unsigned cnt;
		int unsigned lane;
		int unsigned pos;
		logic [32:0] last;
		r = '0;
		cnt = 1 << size;
		last = {1'b0, addr} + 33'(cnt - 1);
		if (last >= 33'(IMAGE_BYTES)) begin
			r.range_error = 1'b1;
			return r;
		end
		for (int unsigned i = 0; i < cnt; i++) begin
			lane = byte_order_le ? i : (cnt - 1 - i);
			pos = addr + i;
			if (op == sbma_pkg::OP_WRITE)
				mem_image[pos] = wval[8*lane +: 8];
			else
				r.read_value[8*lane +: 8] = mem_image[pos];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic send_access(input sbma_pkg::op_t op, input logic [1:0] size,
			input logic [31:0] addr, input sbma_pkg::word_t wval, input bit typed,
			input mem_result_t want);
		mem_result_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, wval, addr, size};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = predict_access(op, size, addr, wval);
		expected_results.push_back(typed ? want : r);
		if (op == sbma_pkg::OP_WRITE)
			write_count++;
		else
			read_count++;
	endtask

	task automatic send_random_access();
		sbma_pkg::op_t op;
		logic [1:0] size;
		logic [31:0] addr;
		int unsigned pick;
		op = sbma_pkg::op_t'($urandom_range(1));
		size = 2'($urandom_range(3));
		pick = $urandom_range(99);
		if (pick < 55)
			addr = $urandom_range(63);
		else if (pick < 70)
			addr = IMAGE_BYTES - $urandom_range(16, 1);
		else if (pick < 80)
			addr = 32'd32760 + $urandom_range(15);
		else if (pick < 90)
			addr = $urandom_range(IMAGE_BYTES - 1);
		else
			addr = $urandom;
		send_access(op, size, addr, {$urandom, $urandom}, 1'b0, '0);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_byte_order(input logic le);
		drain_results();
		cfg_wen <= 1'b1;
		cfg_wdata <= le;
		@(posedge clk);
		byte_order_le = le;
		cfg_wen <= 1'b0;
	endtask

	task automatic run_phase(input logic le, input int unsigned src_pct, input int unsigned rcv_pct);
		set_byte_order(le);
		src_idle_pct = src_pct;
		rcv_idle_pct = rcv_pct;
		repeat (PHASE_ITEMS) send_random_access();
	endtask

	always @(posedge clk) begin : result_check
		mem_result_t want;
		if (m_tvalid && m_tready) begin
			if (m_tuser)
				refused_count++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%h err=%b", m_tdata, m_tuser));
			end else begin
				want = expected_results.pop_front();
				if (m_tdata !== want.read_value)
					report_mismatch($sformatf("read_value %h, want %h", m_tdata, want.read_value));
				if (m_tuser !== want.range_error)
					report_mismatch($sformatf("range_error %b, want %b", m_tuser,
						want.range_error));
			end
		end
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results pending",
				stall_cycles, expected_results.size());
			$display("sized_byte_memory_access_test failed");
			$finish;
		end
	end

	initial begin
		directed_rows = '{
			'{sbma_pkg::OP_READ,  SZ_BYTE,  32'd0,        64'd0,               1'b1, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_DWORD, 32'd65528,    64'd0,               1'b1, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_DWORD, 32'd65529,    64'd0,               1'b1, '{64'd0, 1'b1}},
			'{sbma_pkg::OP_READ,  SZ_BYTE,  32'd65535,    64'd0,               1'b1, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_HALF,  32'd65535,    64'd0,               1'b1, '{64'd0, 1'b1}},
			'{sbma_pkg::OP_WRITE, SZ_DWORD, 32'd0,        64'h0123456789abcdef, 1'b1, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_DWORD, 32'd0,        64'd0,               1'b0, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_WORD,  32'd1,        64'd0,               1'b0, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_HALF,  32'd7,        64'd0,               1'b0, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_WRITE, SZ_BYTE,  32'd65535,    64'hffffffffffffffff, 1'b1, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_BYTE,  32'd65535,    64'd0,               1'b0, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_WRITE, SZ_DWORD, 32'd65529,    64'hffffffffffffffff, 1'b1, '{64'd0, 1'b1}},
			'{sbma_pkg::OP_READ,  SZ_DWORD, 32'd65528,    64'd0,               1'b0, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_WRITE, SZ_WORD,  32'hffffffff, 64'hffffffffffffffff, 1'b1, '{64'd0, 1'b1}},
			'{sbma_pkg::OP_READ,  SZ_DWORD, 32'hffffffff, 64'd0,               1'b1, '{64'd0, 1'b1}},
			'{sbma_pkg::OP_WRITE, SZ_HALF,  32'hfffffffe, 64'h5a5a5a5a5a5a5a5a, 1'b1, '{64'd0, 1'b1}},
			'{sbma_pkg::OP_WRITE, SZ_DWORD, 32'd8,        64'd0,               1'b1, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_WRITE, SZ_WORD,  32'd13,       64'hffffffffffffffff, 1'b1, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_DWORD, 32'd8,        64'd0,               1'b0, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_DWORD, 32'd12,       64'd0,               1'b0, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_WORD,  32'd32768,    64'd0,               1'b1, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_WRITE, SZ_DWORD, 32'd32764,    64'hfedcba9876543210, 1'b1, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_DWORD, 32'd32764,    64'd0,               1'b0, '{64'd0, 1'b0}},
			'{sbma_pkg::OP_READ,  SZ_BYTE,  32'h00010000, 64'd0,               1'b1, '{64'd0, 1'b1}}
		};
		for (int i = 0; i < IMAGE_BYTES; i++)
			mem_image[i] = 8'h00;
		byte_order_le = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 30;
		rcv_idle_pct = 49;
		set_byte_order(LE_ORDER);
		foreach (directed_rows[k])
			send_access(directed_rows[k].op, directed_rows[k].size, directed_rows[k].addr,
				directed_rows[k].wval, directed_rows[k].typed, directed_rows[k].want);

		run_phase(BE_ORDER, 30, 49);
		run_phase(LE_ORDER, 49, 30);
		run_phase(BE_ORDER, 0, 0);
		drain_results();

		$display("covered %0d accesses: %0d reads, %0d writes, %0d refused",
			read_count + write_count, read_count, write_count, refused_count);
		$display("both byte orders, three idle patterns, edges of memory and address space");
		if (mismatch_count == 0)
			$display("sized_byte_memory_access_test passed");
		else
			$display("sized_byte_memory_access_test failed");
		$finish;
	end

endmodule
